// File: design/rot_pkg.sv
// ============================================================================
// Recursive owner table package
// Shared widths, status codes and memory control types.
// ============================================================================
package rot_pkg;

    // Fixed field widths of the channels.
    localparam int KEY_W       = 64;
    localparam int THREAD_W    = 8;
    localparam int STATUS_W    = 4;
    localparam int DEPTH_OUT_W = 16;
    localparam int COUNT_OUT_W = 5;

    // Defaults for the top-level parameters.
    localparam int CAPACITY_DEF       = 16;
    localparam int THREAD_ID_BITS_DEF = 8;
    localparam int DEPTH_BITS_DEF     = 16;

    // Request actions.
    localparam logic ACT_ENTER = 1'b0;
    localparam logic ACT_EXIT  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_IGNORED      = 4'd0;
    localparam logic [STATUS_W-1:0] ST_NEW          = 4'd1;
    localparam logic [STATUS_W-1:0] ST_REENTERED    = 4'd2;
    localparam logic [STATUS_W-1:0] ST_FOREIGN      = 4'd3;
    localparam logic [STATUS_W-1:0] ST_FULL         = 4'd4;
    localparam logic [STATUS_W-1:0] ST_RELEASED     = 4'd5;
    localparam logic [STATUS_W-1:0] ST_REMOVED      = 4'd6;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN_EXIT = 4'd7;
    localparam logic [STATUS_W-1:0] ST_SATURATED    = 4'd8;

    // Strobes from the controller to the entry memory.
    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_ctl;

endpackage

// File: design/rot_if.sv
// ============================================================================
// Recursive owner table channel interfaces
// Request and result channels with a valid/ready handshake.
// ============================================================================

// Request channel: one enter or exit per transfer.
interface rot_req_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [rot_pkg::KEY_W-1:0]     object_key;
    logic [rot_pkg::THREAD_W-1:0]  thread_id;
    logic                          is_concurrent;

    modport source (output valid, action, object_key, thread_id, is_concurrent,
                    input ready);
    modport sink   (input valid, action, object_key, thread_id, is_concurrent,
                    output ready);
endinterface

// Result channel: one result per request.
interface rot_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [rot_pkg::STATUS_W-1:0]     status;
    logic [rot_pkg::DEPTH_OUT_W-1:0]  depth_now;
    logic [rot_pkg::COUNT_OUT_W-1:0]  entries_in_use;

    modport source (output valid, status, depth_now, entries_in_use, input ready);
    modport sink   (input valid, status, depth_now, entries_in_use, output ready);
endinterface

// File: design/rot_entry_mem.sv
// ============================================================================
// Entry memory
// Single-port-write, single-port-read synchronous memory holding the packed
// key, owner and depth of each table entry. Read data arrives in the cycle after the read.
// ============================================================================
module rot_entry_mem #(
    parameter int ENTRIES = rot_pkg::CAPACITY_DEF,
    parameter int WORD_W  = rot_pkg::KEY_W + rot_pkg::THREAD_ID_BITS_DEF
                            + rot_pkg::DEPTH_BITS_DEF
) (
    input  logic                       i_clk,
    input  rot_pkg::t_mem_ctl          i_ctl,
    input  logic [$clog2(ENTRIES)-1:0] i_rd_addr,
    input  logic [$clog2(ENTRIES)-1:0] i_wr_addr,
    input  logic [WORD_W-1:0]          i_wr_data,
    output logic [WORD_W-1:0]          o_rd_data
);

    logic [WORD_W-1:0] r_mem [ENTRIES];
    logic [WORD_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/rot_ctrl.sv
// ============================================================================
// Owner table controller
// Scans the entry memory for the requested key, decides the outcome, writes
// the updated entry back and presents the result in an output register.
// ============================================================================
module rot_ctrl #(
    parameter int CAPACITY       = rot_pkg::CAPACITY_DEF,
    parameter int THREAD_ID_BITS = rot_pkg::THREAD_ID_BITS_DEF,
    parameter int DEPTH_BITS     = rot_pkg::DEPTH_BITS_DEF,
    parameter int IDX_W          = $clog2(CAPACITY),
    parameter int WORD_W         = rot_pkg::KEY_W + THREAD_ID_BITS + DEPTH_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rot_req_if.sink               i_in,
    rot_rsp_if.source             o_out,
    output rot_pkg::t_mem_ctl     o_mem_ctl,
    output logic [IDX_W-1:0]      o_rd_addr,
    output logic [IDX_W-1:0]      o_wr_addr,
    output logic [WORD_W-1:0]     o_wr_data,
    input  logic [WORD_W-1:0]     i_rd_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int KW    = rot_pkg::KEY_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_MOVE   = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0]                   r_state;
    logic [CNT_W-1:0]             r_used;
    logic                         r_act;
    logic [KW-1:0]                r_key;
    logic [THREAD_ID_BITS-1:0]    r_self;
    logic                         r_conc;
    logic [IDX_W-1:0]             r_idx;
    logic                         r_found;
    logic [THREAD_ID_BITS-1:0]    r_hit_owner;
    logic [DEPTH_BITS-1:0]        r_hit_depth;
    logic [rot_pkg::STATUS_W-1:0] r_status;
    logic [DEPTH_BITS-1:0]        r_depth;
    logic                         r_out_valid;
    logic [rot_pkg::STATUS_W-1:0] r_out_status;
    logic [DEPTH_BITS-1:0]        r_out_depth;
    logic [CNT_W-1:0]             r_out_count;

    logic [THREAD_ID_BITS-1:0]    self_in;
    logic [KW-1:0]                rd_key;
    logic [THREAD_ID_BITS-1:0]    rd_owner;
    logic [DEPTH_BITS-1:0]        rd_depth;
    logic [CNT_W-1:0]             last_cnt;
    logic                         scan_last;
    logic                         in_xfer;
    logic                         out_free;

    // Keep the low thread bits of the request, zero-extended if the owner is wider.
    if (THREAD_ID_BITS <= rot_pkg::THREAD_W) begin : g_self_cut
        assign self_in = i_in.thread_id[THREAD_ID_BITS-1:0];
    end else begin : g_self_ext
        assign self_in = {{(THREAD_ID_BITS - rot_pkg::THREAD_W){1'b0}}, i_in.thread_id};
    end

    // Result fields resized to the channel widths.
    if (DEPTH_BITS >= rot_pkg::DEPTH_OUT_W) begin : g_depth_cut
        assign o_out.depth_now = r_out_depth[rot_pkg::DEPTH_OUT_W-1:0];
    end else begin : g_depth_ext
        assign o_out.depth_now = {{(rot_pkg::DEPTH_OUT_W - DEPTH_BITS){1'b0}}, r_out_depth};
    end

    if (CNT_W >= rot_pkg::COUNT_OUT_W) begin : g_count_cut
        assign o_out.entries_in_use = r_out_count[rot_pkg::COUNT_OUT_W-1:0];
    end else begin : g_count_ext
        assign o_out.entries_in_use = {{(rot_pkg::COUNT_OUT_W - CNT_W){1'b0}}, r_out_count};
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.status = r_out_status;

    // Handshakes and helpers.
    assign i_in.ready = (r_state == S_IDLE);
    assign in_xfer    = i_in.valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || o_out.ready;
    assign last_cnt   = r_used - CNT_W'(1);
    assign scan_last  = (CNT_W'(r_idx) == last_cnt);

    // Unpack the entry word read from memory.
    assign rd_key   = i_rd_data[WORD_W-1 -: KW];
    assign rd_owner = i_rd_data[DEPTH_BITS +: THREAD_ID_BITS];
    assign rd_depth = i_rd_data[DEPTH_BITS-1:0];

    // Memory requests. Writes happen only in DECIDE and MOVE, reads in IDLE, SCAN
    // and DECIDE but never with a write, so a read never meets a write to the same entry.
    always_comb begin
        o_mem_ctl = '0;
        o_rd_addr = '0;
        o_wr_addr = r_idx;
        o_wr_data = {r_key, r_hit_owner, r_hit_depth};
        unique case (r_state)
            S_IDLE: begin
                o_mem_ctl.rd = in_xfer && (r_used != '0);
            end
            S_SCAN: begin
                o_mem_ctl.rd = (rd_key != r_key) && !scan_last;
                o_rd_addr    = r_idx + IDX_W'(1);
            end
            S_DECIDE: begin
                if (r_act == rot_pkg::ACT_ENTER) begin
                    if (!r_conc && r_found && (r_hit_owner == r_self)
                            && !(&r_hit_depth)) begin
                        o_mem_ctl.wr = 1'b1;
                        o_wr_data    = {r_key, r_hit_owner, r_hit_depth + DEPTH_BITS'(1)};
                    end else if (!r_conc && !r_found && (r_used < CNT_W'(CAPACITY))) begin
                        o_mem_ctl.wr = 1'b1;
                        o_wr_addr    = r_used[IDX_W-1:0];
                        o_wr_data    = {r_key, r_self, DEPTH_BITS'(1)};
                    end
                end else if (r_found) begin
                    if (r_hit_depth > DEPTH_BITS'(1)) begin
                        o_mem_ctl.wr = 1'b1;
                        o_wr_data    = {r_key, r_hit_owner, r_hit_depth - DEPTH_BITS'(1)};
                    end else begin
                        // Removal: fetch the last entry to move into the freed slot.
                        o_mem_ctl.rd = (CNT_W'(r_idx) != last_cnt);
                        o_rd_addr    = last_cnt[IDX_W-1:0];
                    end
                end
            end
            S_MOVE: begin
                o_mem_ctl.wr = 1'b1;
                o_wr_data    = i_rd_data;
            end
            default: begin
                o_mem_ctl = '0;
            end
        endcase
    end

    // Sequencer and result datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            // The output register fills from EMIT and empties on a result transfer.
            if ((r_state == S_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_act   <= i_in.action;
                        r_key   <= i_in.object_key;
                        r_self  <= self_in;
                        r_conc  <= i_in.is_concurrent;
                        r_found <= 1'b0;
                        r_idx   <= '0;
                        r_state <= (r_used == '0) ? S_DECIDE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    // Data on the read port belongs to entry r_idx.
                    if (rd_key == r_key) begin
                        r_found     <= 1'b1;
                        r_hit_owner <= rd_owner;
                        r_hit_depth <= rd_depth;
                        r_state     <= S_DECIDE;
                    end else if (scan_last) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_DECIDE: begin
                    r_state <= S_EMIT;
                    if (r_act == rot_pkg::ACT_ENTER) begin
                        if (r_conc) begin
                            r_status <= rot_pkg::ST_IGNORED;
                            r_depth  <= r_found ? r_hit_depth : '0;
                        end else if (r_found) begin
                            if (r_hit_owner != r_self) begin
                                r_status <= rot_pkg::ST_FOREIGN;
                                r_depth  <= r_hit_depth;
                            end else if (&r_hit_depth) begin
                                r_status <= rot_pkg::ST_SATURATED;
                                r_depth  <= r_hit_depth;
                            end else begin
                                r_status <= rot_pkg::ST_REENTERED;
                                r_depth  <= r_hit_depth + DEPTH_BITS'(1);
                            end
                        end else if (r_used >= CNT_W'(CAPACITY)) begin
                            r_status <= rot_pkg::ST_FULL;
                            r_depth  <= '0;
                        end else begin
                            r_status <= rot_pkg::ST_NEW;
                            r_depth  <= DEPTH_BITS'(1);
                            r_used   <= r_used + CNT_W'(1);
                        end
                    end else if (!r_found) begin
                        r_status <= rot_pkg::ST_UNKNOWN_EXIT;
                        r_depth  <= '0;
                    end else if (r_hit_depth > DEPTH_BITS'(1)) begin
                        r_status <= rot_pkg::ST_RELEASED;
                        r_depth  <= r_hit_depth - DEPTH_BITS'(1);
                    end else begin
                        r_status <= rot_pkg::ST_REMOVED;
                        r_depth  <= '0;
                        r_used   <= last_cnt;
                        if (CNT_W'(r_idx) != last_cnt) begin
                            r_state <= S_MOVE;
                        end
                    end
                end
                S_MOVE: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // Hand the result to the output register once it is free.
                    if (out_free) begin
                        r_out_status <= r_status;
                        r_out_depth  <= r_depth;
                        r_out_count  <= r_used;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/recursive_owner_table.sv
// ============================================================================
// Recursive owner table
// Table of held objects with owner thread and nesting depth, kept in a
// synchronous entry memory and updated by read-modify-write.
// ============================================================================
//
//  Channel  Direction  Handshake     Payload
//  i_in     request    valid/ready   action, object_key, thread_id, is_concurrent
//  o_out    result     valid/ready   status, depth_now, entries_in_use
//
// A request passes through the states IDLE, SCAN, DECIDE, MOVE and EMIT in
// that order. SCAN reads one entry per cycle until the key matches or the last
// entry in use has been read, and is skipped when the table is empty; MOVE only
// occurs when a removal moves the last entry into the freed slot.
// Reset clears the entry count and the control state; the memory needs no clear.
// A new request is taken while the previous result still waits in the output
// register; a stalled result holds the sequencer before its result is loaded.
// ============================================================================
module recursive_owner_table #(
    parameter int CAPACITY       = rot_pkg::CAPACITY_DEF,
    parameter int THREAD_ID_BITS = rot_pkg::THREAD_ID_BITS_DEF,
    parameter int DEPTH_BITS     = rot_pkg::DEPTH_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rot_req_if.sink    i_in,
    rot_rsp_if.source  o_out
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int WORD_W = rot_pkg::KEY_W + THREAD_ID_BITS + DEPTH_BITS;

    rot_pkg::t_mem_ctl  mem_ctl;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic [WORD_W-1:0]  rd_data;

    // Sequencer and result path.
    rot_ctrl #(
        .CAPACITY       (CAPACITY),
        .THREAD_ID_BITS (THREAD_ID_BITS),
        .DEPTH_BITS     (DEPTH_BITS),
        .IDX_W          (IDX_W),
        .WORD_W         (WORD_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_mem_ctl (mem_ctl),
        .o_rd_addr (rd_addr),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .i_rd_data (rd_data)
    );

    // Entry storage.
    rot_entry_mem #(
        .ENTRIES (CAPACITY),
        .WORD_W  (WORD_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

endmodule

// File: dv/tb_recursive_owner_table.sv
// ============================================================================
// Recursive owner table testbench
// Sends enter and exit requests through the request channel and checks
// every result against a behavioral copy of the owner table. The run starts
// with a directed part, then random bursts that fill and drain the table
// under changing backpressure. It ends by nesting one object deeply.
// ============================================================================
module tb_recursive_owner_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     HALF_PERIOD = 10;
    localparam longint TIMEOUT_NS  = 80_000_000;
    localparam int     CAPACITY    = rot_pkg::CAPACITY_DEF;
    localparam int     DEPTH_BITS  = rot_pkg::DEPTH_BITS_DEF;
    localparam int     KEY_W       = rot_pkg::KEY_W;
    localparam int     THREAD_W    = rot_pkg::THREAD_W;
    localparam int     COUNT_OUT_W = rot_pkg::COUNT_OUT_W;
    localparam int     POOL_SIZE   = 20;
    localparam int     BURST_LEN   = 60;
    localparam int     DEEP_ENTERS = 24;
    localparam int     SETTLE_CYCLES = 40;
    localparam int     PRINT_LIMIT = 40;
    localparam logic [DEPTH_BITS-1:0] MAX_DEPTH = '1;

    typedef struct {
        logic                action;
        logic [KEY_W-1:0]    object_key;
        logic [THREAD_W-1:0] thread_id;
        logic                is_concurrent;
    } t_owner_req;

    typedef struct {
        logic [rot_pkg::STATUS_W-1:0]    status;
        logic [rot_pkg::DEPTH_OUT_W-1:0] depth_now;
        logic [COUNT_OUT_W-1:0]          entries_in_use;
    } t_owner_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rot_req_if req_ch ();
    rot_rsp_if rsp_ch ();

    recursive_owner_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    // Shadow copy of the owner table.
    logic [KEY_W-1:0]      held_key   [CAPACITY];
    logic [THREAD_W-1:0]   held_owner [CAPACITY];
    logic [DEPTH_BITS-1:0] held_depth [CAPACITY];
    int                    held_count = 0;

    t_owner_req    pending_requests [$];
    t_owner_result expected_results [$];
    t_owner_req    req_in_flight;

    // Keys that the random part works on, each with a usual owner thread.
    logic [KEY_W-1:0]    pool_key    [POOL_SIZE];
    logic [THREAD_W-1:0] pool_thread [POOL_SIZE];

    int send_gap_pct;
    int recv_stall_pct;
    int mismatch_count = 0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Updates the shadow table for one request and returns its result.
    function automatic t_owner_result apply_to_table(input t_owner_req r);
        t_owner_result res;
        int            slot;
        int            i;
        slot = CAPACITY;
        for (i = 0; i < held_count; i++) begin
            if (slot == CAPACITY && held_key[i] == r.object_key) begin
                slot = i;
            end
        end
        res.depth_now = '0;
        if (r.action == rot_pkg::ACT_ENTER) begin
            if (r.is_concurrent) begin
                res.status = rot_pkg::ST_IGNORED;
                if (slot < CAPACITY) begin
                    res.depth_now = held_depth[slot];
                end
            end else if (slot < CAPACITY) begin
                if (held_owner[slot] != r.thread_id) begin
                    res.status = rot_pkg::ST_FOREIGN;
                end else if (held_depth[slot] == MAX_DEPTH) begin
                    res.status = rot_pkg::ST_SATURATED;
                end else begin
                    held_depth[slot] = held_depth[slot] + DEPTH_BITS'(1);
                    res.status = rot_pkg::ST_REENTERED;
                end
                res.depth_now = held_depth[slot];
            end else if (held_count >= CAPACITY) begin
                res.status = rot_pkg::ST_FULL;
            end else begin
                held_key[held_count]   = r.object_key;
                held_owner[held_count] = r.thread_id;
                held_depth[held_count] = DEPTH_BITS'(1);
                held_count++;
                res.status    = rot_pkg::ST_NEW;
                res.depth_now = DEPTH_BITS'(1);
            end
        end else begin
            if (slot == CAPACITY) begin
                res.status = rot_pkg::ST_UNKNOWN_EXIT;
            end else if (held_depth[slot] <= DEPTH_BITS'(1)) begin
                // The last entry moves into the freed slot.
                held_key[slot]   = held_key[held_count-1];
                held_owner[slot] = held_owner[held_count-1];
                held_depth[slot] = held_depth[held_count-1];
                held_count--;
                res.status = rot_pkg::ST_REMOVED;
            end else begin
                held_depth[slot] = held_depth[slot] - DEPTH_BITS'(1);
                res.status    = rot_pkg::ST_RELEASED;
                res.depth_now = held_depth[slot];
            end
        end
        res.entries_in_use = held_count[COUNT_OUT_W-1:0];
        return res;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("%0t ns: mismatch: %s", $realtime, msg);
        end
    endtask

    function automatic t_owner_req make_request(input logic act, input logic [KEY_W-1:0] key,
                                                input logic [THREAD_W-1:0] thread,
                                                input logic conc);
        t_owner_req r;
        r.action        = act;
        r.object_key    = key;
        r.thread_id     = thread;
        r.is_concurrent = conc;
        return r;
    endfunction

    // Random request; while filling, enters dominate, while draining, exits.
    function automatic t_owner_req random_request(input bit filling);
        t_owner_req r;
        int         idx;
        idx = $urandom_range(POOL_SIZE-1);
        r.thread_id     = THREAD_W'($urandom_range(255));
        r.is_concurrent = 1'($urandom_range(1));
        r.object_key    = pool_key[idx];
        if ($urandom_range(99) < (filling ? 70 : 30)) begin
            r.action        = rot_pkg::ACT_ENTER;
            r.is_concurrent = ($urandom_range(99) < 8);
            if (r.is_concurrent && $urandom_range(1) == 1) begin
                r.object_key = {$urandom, $urandom};
            end
            if ($urandom_range(99) < 85) begin
                r.thread_id = pool_thread[idx];
            end else begin
                r.thread_id = pool_thread[idx] ^ THREAD_W'($urandom_range(255, 1));
            end
        end else begin
            r.action = rot_pkg::ACT_EXIT;
            if ($urandom_range(99) < 5) begin
                r.object_key = {$urandom, $urandom};
            end
        end
        return r;
    endfunction

    task automatic wait_table_idle();
        while (pending_requests.size() != 0 || req_ch.valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_random_phase(input int count, input int gap_pct, input int stall_pct);
        bit filling;
        int n;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        filling = 1'b1;
        for (n = 0; n < count; n++) begin
            if (n % BURST_LEN == BURST_LEN - 1) begin
                filling = ~filling;
            end
            pending_requests.push_back(random_request(filling));
        end
        wait_table_idle();
    endtask

    // Request driver: launches the next pending request when the channel is free.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid         <= 1'b0;
            req_ch.action        <= rot_pkg::ACT_ENTER;
            req_ch.object_key    <= '0;
            req_ch.thread_id     <= '0;
            req_ch.is_concurrent <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                expected_results.push_back(apply_to_table(req_in_flight));
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    req_in_flight = pending_requests.pop_front();
                    req_ch.valid         <= 1'b1;
                    req_ch.action        <= req_in_flight.action;
                    req_ch.object_key    <= req_in_flight.object_key;
                    req_ch.thread_id     <= req_in_flight.thread_id;
                    req_ch.is_concurrent <= req_in_flight.is_concurrent;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each transfer against the oldest expectation.
    always @(posedge i_clk) begin
        t_owner_result exp_res;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_results.size() == 0) begin
                    note_mismatch($sformatf("result with nothing expected, status %0d",
                                            rsp_ch.status));
                end else begin
                    exp_res = expected_results.pop_front();
                    if (rsp_ch.status !== exp_res.status) begin
                        note_mismatch($sformatf("status %0d, expected %0d",
                                                rsp_ch.status, exp_res.status));
                    end
                    if (rsp_ch.depth_now !== exp_res.depth_now) begin
                        note_mismatch($sformatf("depth_now %0d, expected %0d",
                                                rsp_ch.depth_now, exp_res.depth_now));
                    end
                    if (rsp_ch.entries_in_use !== exp_res.entries_in_use) begin
                        note_mismatch($sformatf("entries_in_use %0d, expected %0d",
                                                rsp_ch.entries_in_use, exp_res.entries_in_use));
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Run limit.
    initial begin
        #(TIMEOUT_NS);
        $display("tb_recursive_owner_table: done, errors");
        $finish;
    end

    initial begin
        logic [KEY_W-1:0]      drain_key   [CAPACITY];
        logic [DEPTH_BITS-1:0] drain_depth [CAPACITY];
        int                    drain_count;
        logic [KEY_W-1:0]      deep_key;
        logic [THREAD_W-1:0]   deep_thread;
        int                    i;
        int                    j;

        i_rst_n = 1'b0;
        send_gap_pct   = 6;
        recv_stall_pct = 73;

        pool_key[0]    = '1;
        pool_key[1]    = '0;
        pool_thread[0] = 8'hFF;
        pool_thread[1] = 8'h00;
        for (i = 2; i < POOL_SIZE; i++) begin
            pool_key[i]    = {$urandom, $urandom};
            pool_thread[i] = THREAD_W'($urandom_range(255));
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: unknown exit, new, reenter, foreign, concurrent, exit by any thread.
        pending_requests.push_back(make_request(rot_pkg::ACT_EXIT,  '0, 8'h00, 1'b0));
        pending_requests.push_back(make_request(rot_pkg::ACT_ENTER, '0, 8'h00, 1'b0));
        pending_requests.push_back(make_request(rot_pkg::ACT_ENTER, '0, 8'h00, 1'b0));
        pending_requests.push_back(make_request(rot_pkg::ACT_ENTER, '0, 8'hFF, 1'b0));
        pending_requests.push_back(make_request(rot_pkg::ACT_ENTER, '0, 8'hFF, 1'b1));
        pending_requests.push_back(make_request(rot_pkg::ACT_ENTER, '1, 8'h00, 1'b1));
        pending_requests.push_back(make_request(rot_pkg::ACT_EXIT,  '0, 8'hFF, 1'b1));
        pending_requests.push_back(make_request(rot_pkg::ACT_EXIT,  '0, 8'h00, 1'b0));

        // Directed: fill the table, overflow it, then remove the first slot.
        for (i = 0; i < CAPACITY; i++) begin
            pending_requests.push_back(make_request(rot_pkg::ACT_ENTER, pool_key[i],
                                                    pool_thread[i], 1'b0));
        end
        pending_requests.push_back(make_request(rot_pkg::ACT_ENTER, pool_key[CAPACITY],
                                                pool_thread[CAPACITY], 1'b0));
        pending_requests.push_back(make_request(rot_pkg::ACT_EXIT, pool_key[0], 8'h5A, 1'b0));
        wait_table_idle();

        // Random bursts under three backpressure patterns.
        run_random_phase(500, 6, 73);
        run_random_phase(500, 73, 6);
        run_random_phase(450, 0, 0);

        // Empty the table so the nesting run scans a single entry.
        drain_count = held_count;
        for (i = 0; i < drain_count; i++) begin
            drain_key[i]   = held_key[i];
            drain_depth[i] = held_depth[i];
        end
        for (i = 0; i < drain_count; i++) begin
            for (j = 0; j < drain_depth[i]; j++) begin
                pending_requests.push_back(make_request(rot_pkg::ACT_EXIT, drain_key[i],
                                                        THREAD_W'($urandom_range(255)),
                                                        1'($urandom_range(1))));
            end
        end

        // Nest one object deeply, release once, enter again, then try other threads on it.
        deep_key    = {$urandom, $urandom};
        deep_thread = THREAD_W'($urandom_range(255));
        for (i = 0; i < DEEP_ENTERS; i++) begin
            pending_requests.push_back(make_request(rot_pkg::ACT_ENTER, deep_key,
                                                    deep_thread, 1'b0));
        end
        pending_requests.push_back(make_request(rot_pkg::ACT_EXIT,  deep_key, deep_thread, 1'b0));
        pending_requests.push_back(make_request(rot_pkg::ACT_ENTER, deep_key, deep_thread, 1'b0));
        pending_requests.push_back(make_request(rot_pkg::ACT_ENTER, deep_key, ~deep_thread, 1'b1));
        pending_requests.push_back(make_request(rot_pkg::ACT_ENTER, deep_key, ~deep_thread, 1'b0));
        wait_table_idle();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_recursive_owner_table: done, clean");
        end else begin
            $display("tb_recursive_owner_table: done, errors");
        end
        $finish;
    end

endmodule
